>>> rtl/nec_ir_pkg.sv
// Shared types, constants and a helper function for the infrared pulse-distance transmitter.
package nec_ir_pkg;

  localparam int unsigned CodeWidth = 64;
  localparam int unsigned CountWidth = 7;
  localparam int unsigned DurWidth = 16;
  localparam int unsigned HalfWidth = 8;
  localparam int unsigned CycWidth = 12;
  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;

  localparam int unsigned UsPerCycle = 21;
  localparam logic [16:0] Recip21 = 17'd99865;
  localparam int unsigned RecipShift = 21;

  localparam logic [DurWidth-1:0] RstHeaderMark = 16'd9000;
  localparam logic [DurWidth-1:0] RstHeaderSpace = 16'd4500;
  localparam logic [DurWidth-1:0] RstBitMark = 16'd560;
  localparam logic [DurWidth-1:0] RstZeroSpace = 16'd560;
  localparam logic [DurWidth-1:0] RstOneSpace = 16'd1690;
  localparam logic [HalfWidth-1:0] RstCarrierHalf = 8'd13;
  localparam logic [CycWidth-1:0] RstHeaderCyc = CycWidth'(9000 / UsPerCycle);
  localparam logic [CycWidth-1:0] RstBitCyc = CycWidth'(560 / UsPerCycle);

  typedef enum logic [2:0] {
    REG_HEADER_MARK  = 3'd0,
    REG_HEADER_SPACE = 3'd1,
    REG_BIT_MARK     = 3'd2,
    REG_ZERO_SPACE   = 3'd3,
    REG_ONE_SPACE    = 3'd4,
    REG_CARRIER_HALF = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_HMARK  = 3'd1,
    PH_HSPACE = 3'd2,
    PH_BMARK  = 3'd3,
    PH_BSPACE = 3'd4
  } phase_t;

  typedef struct packed {
    logic [CycWidth-1:0]  header_cyc;
    logic [CycWidth-1:0]  bit_cyc;
    logic [DurWidth-1:0]  header_space;
    logic [DurWidth-1:0]  zero_space;
    logic [DurWidth-1:0]  one_space;
    logic [HalfWidth-1:0] half;
  } cfg_t;

  typedef struct packed {
    logic pin;
    logic busy;
  } res_t;

  // Whole carrier cycles in a mark of the given length, by reciprocal multiplication.
  function automatic logic [CycWidth-1:0] mark_cycles(input logic [DurWidth-1:0] us);
    logic [32:0] prod;
    prod = 33'(us) * 33'(Recip21);
    return prod[RecipShift+CycWidth-1:RecipShift];
  endfunction

endpackage

>>> rtl/nec_ir_cfg.sv
// Register file of the configuration port, with precomputed carrier cycle counts.
module nec_ir_cfg
  import nec_ir_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output cfg_t                 cfg
);

  logic [DurWidth-1:0]  header_mark;
  logic [DurWidth-1:0]  header_space;
  logic [DurWidth-1:0]  bit_mark;
  logic [DurWidth-1:0]  zero_space;
  logic [DurWidth-1:0]  one_space;
  logic [HalfWidth-1:0] carrier_half;
  logic [CycWidth-1:0]  header_cyc;
  logic [CycWidth-1:0]  bit_cyc;
  logic                 wr;
  reg_idx_t             idx;

  assign wr  = psel && penable && pwrite;
  assign idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      header_mark  <= RstHeaderMark;
      header_space <= RstHeaderSpace;
      bit_mark     <= RstBitMark;
      zero_space   <= RstZeroSpace;
      one_space    <= RstOneSpace;
      carrier_half <= RstCarrierHalf;
      header_cyc   <= RstHeaderCyc;
      bit_cyc      <= RstBitCyc;
    end else if (wr) begin
      case (idx)
        REG_HEADER_MARK: begin
          header_mark <= pwdata[DurWidth-1:0];
          header_cyc  <= mark_cycles(pwdata[DurWidth-1:0]);
        end
        REG_HEADER_SPACE: header_space <= pwdata[DurWidth-1:0];
        REG_BIT_MARK: begin
          bit_mark <= pwdata[DurWidth-1:0];
          bit_cyc  <= mark_cycles(pwdata[DurWidth-1:0]);
        end
        REG_ZERO_SPACE:   zero_space <= pwdata[DurWidth-1:0];
        REG_ONE_SPACE:    one_space <= pwdata[DurWidth-1:0];
        REG_CARRIER_HALF: carrier_half <= pwdata[HalfWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_HEADER_MARK:  prdata = DataWidth'(header_mark);
      REG_HEADER_SPACE: prdata = DataWidth'(header_space);
      REG_BIT_MARK:     prdata = DataWidth'(bit_mark);
      REG_ZERO_SPACE:   prdata = DataWidth'(zero_space);
      REG_ONE_SPACE:    prdata = DataWidth'(one_space);
      REG_CARRIER_HALF: prdata = DataWidth'(carrier_half);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    cfg.header_cyc   = header_cyc;
    cfg.bit_cyc      = bit_cyc;
    cfg.header_space = header_space;
    cfg.zero_space   = zero_space;
    cfg.one_space    = one_space;
    cfg.half         = (carrier_half == '0) ? HalfWidth'(1) : carrier_half;
  end

endmodule

>>> rtl/nec_ir_find.sv
// Search for the next code bit that takes time, and the bits still pending after it.
module nec_ir_find
  import nec_ir_pkg::*;
(
  input  logic [CodeWidth-1:0] pend,
  input  logic [CodeWidth-1:0] code,
  input  logic                 mark_on,
  input  logic                 zero_on,
  input  logic                 one_on,
  output logic                 found,
  output logic                 found_bit,
  output logic [CodeWidth-1:0] pend_next
);

  logic [CodeWidth-1:0] elig;
  logic [CodeWidth-1:0] s1, s2, s4, s8, s16, s32;
  logic [CodeWidth-1:0] onehot;

  // With no bit mark, a bit takes time only when its own space is non-zero.
  assign elig = pend & (mark_on ? {CodeWidth{1'b1}}
                                : ((code & {CodeWidth{one_on}}) |
                                   (~code & {CodeWidth{zero_on}})));

  // Smear the highest eligible bit downwards.
  assign s1  = elig | (elig >> 1);
  assign s2  = s1 | (s1 >> 2);
  assign s4  = s2 | (s2 >> 4);
  assign s8  = s4 | (s4 >> 8);
  assign s16 = s8 | (s8 >> 16);
  assign s32 = s16 | (s16 >> 32);

  assign onehot    = s32 & ~(s32 >> 1);
  assign found     = |elig;
  assign found_bit = |(onehot & code);
  assign pend_next = pend & (s32 >> 1);

endmodule

>>> rtl/nec_ir_seq.sv
// Frame sequencer: phase state, carrier timing and the result of each request.
module nec_ir_seq
  import nec_ir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  go,
  input  logic                  kind,
  input  logic [CodeWidth-1:0]  code_word,
  input  logic [CountWidth-1:0] bit_count,
  input  cfg_t                  cfg,
  output res_t                  res
);

  phase_t               phase, phase_next;
  logic [CycWidth-1:0]  ccl, ccl_next;
  logic [DurWidth-1:0]  tc, tc_next;
  logic                 chigh, chigh_next;
  logic                 cur_bit, cur_bit_next;
  logic [CodeWidth-1:0] pend, pend_next;
  logic [CodeWidth-1:0] code, code_next;

  logic                  start_now;
  logic                  tick_now;
  logic [CountWidth-1:0] n_sat;
  logic [CodeWidth-1:0]  vmask;
  logic [CodeWidth-1:0]  f_pend;
  logic [CodeWidth-1:0]  f_code;
  logic                  f_found;
  logic                  f_bit;
  logic [CodeWidth-1:0]  f_pend_next;
  logic [DurWidth-1:0]   tc_dec;
  logic [CycWidth-1:0]   ccl_dec;
  logic [DurWidth-1:0]   cur_space;
  logic [DurWidth-1:0]   f_space;

  assign start_now = go && kind && (phase == PH_IDLE);
  assign tick_now  = go && !kind && (phase != PH_IDLE);

  assign n_sat = (bit_count > CountWidth'(CodeWidth)) ? CountWidth'(CodeWidth) : bit_count;
  assign vmask = (n_sat == CountWidth'(CodeWidth)) ? {CodeWidth{1'b1}}
               : ((CodeWidth'(1) << n_sat[5:0]) - CodeWidth'(1));

  assign f_pend = start_now ? vmask : pend;
  assign f_code = start_now ? code_word : code;

  nec_ir_find u_find (
    .pend      (f_pend),
    .code      (f_code),
    .mark_on   (cfg.bit_cyc != '0),
    .zero_on   (cfg.zero_space != '0),
    .one_on    (cfg.one_space != '0),
    .found     (f_found),
    .found_bit (f_bit),
    .pend_next (f_pend_next)
  );

  assign tc_dec    = (tc == '0) ? '0 : tc - DurWidth'(1);
  assign ccl_dec   = (ccl == '0) ? '0 : ccl - CycWidth'(1);
  assign cur_space = cur_bit ? cfg.one_space : cfg.zero_space;
  assign f_space   = f_bit ? cfg.one_space : cfg.zero_space;

  always_comb begin
    phase_next   = phase;
    ccl_next     = ccl;
    tc_next      = tc;
    chigh_next   = chigh;
    cur_bit_next = cur_bit;
    pend_next    = pend;
    code_next    = code;
    if (start_now || tick_now) begin
      if (start_now) begin
        code_next = code_word;
        pend_next = vmask;
      end
      if (tick_now && (tc_dec != '0)) begin
        tc_next = tc_dec;
      end else if (tick_now && (phase == PH_HMARK || phase == PH_BMARK) && chigh) begin
        chigh_next = 1'b0;
        tc_next    = DurWidth'(cfg.half);
      end else if (tick_now && (phase == PH_HMARK || phase == PH_BMARK) && (ccl_dec != '0)) begin
        ccl_next   = ccl_dec;
        chigh_next = 1'b1;
        tc_next    = DurWidth'(cfg.half);
      end else if (start_now && (cfg.header_cyc != '0)) begin
        phase_next = PH_HMARK;
        ccl_next   = cfg.header_cyc;
        chigh_next = 1'b1;
        tc_next    = DurWidth'(cfg.half);
      end else if ((start_now || phase == PH_HMARK) && (cfg.header_space != '0)) begin
        phase_next = PH_HSPACE;
        chigh_next = 1'b0;
        tc_next    = cfg.header_space;
      end else if (!start_now && phase == PH_BMARK && (cur_space != '0)) begin
        phase_next = PH_BSPACE;
        chigh_next = 1'b0;
        tc_next    = cur_space;
      end else if (!f_found) begin
        phase_next = PH_IDLE;
        ccl_next   = '0;
        tc_next    = '0;
        chigh_next = 1'b0;
        pend_next  = '0;
      end else if (cfg.bit_cyc != '0) begin
        phase_next   = PH_BMARK;
        ccl_next     = cfg.bit_cyc;
        chigh_next   = 1'b1;
        tc_next      = DurWidth'(cfg.half);
        cur_bit_next = f_bit;
        pend_next    = f_pend_next;
      end else begin
        phase_next   = PH_BSPACE;
        chigh_next   = 1'b0;
        tc_next      = f_space;
        cur_bit_next = f_bit;
        pend_next    = f_pend_next;
      end
    end
  end

  always_comb begin
    if (kind) begin
      res.pin  = (phase_next == PH_HMARK || phase_next == PH_BMARK) && chigh_next;
      res.busy = (phase_next != PH_IDLE);
    end else begin
      res.pin  = (phase == PH_HMARK || phase == PH_BMARK) && chigh;
      res.busy = (phase != PH_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_IDLE;
      ccl     <= '0;
      tc      <= '0;
      chigh   <= 1'b0;
      cur_bit <= 1'b0;
      pend    <= '0;
      code    <= '0;
    end else begin
      phase   <= phase_next;
      ccl     <= ccl_next;
      tc      <= tc_next;
      chigh   <= chigh_next;
      cur_bit <= cur_bit_next;
      pend    <= pend_next;
      code    <= code_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) (phase == PH_IDLE) |-> (pend == '0))
    else $error("Pending code bits remain while idle.");
  assert property (@(posedge clk) disable iff (rst) (phase != PH_IDLE) |-> (tc != '0))
    else $error("A frame phase is running with no ticks left.");
  assert property (@(posedge clk) disable iff (rst)
                   ((phase == PH_HMARK || phase == PH_BMARK) && !chigh) |-> (ccl != '0))
    else $error("A mark is in its low half with no carrier cycle left.");
  assert property (@(posedge clk) disable iff (rst)
                   (phase == PH_HSPACE || phase == PH_BSPACE || phase == PH_IDLE) |-> !chigh)
    else $error("Carrier is high outside a mark.");

endmodule

>>> rtl/nec_ir_pulse_distance_transmitter_top.sv
// Top level of the infrared pulse-distance transmitter: request registers and configuration port.
// Each request passes through the input register and then the result register.
// Throughput: one request per cycle while no result is stalled; the frame state is updated
// in one pass per request. An input register and a result register part the two channels,
// so with the input register free, a request is taken while a finished result still waits.
// Reset is synchronous and active high; it empties both registers, idles the sequencer
// and loads the default frame timing.
module nec_ir_pulse_distance_transmitter_top
  import nec_ir_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AddrWidth-1:0]  paddr,
  input  logic [DataWidth-1:0]  pwdata,
  output logic [DataWidth-1:0]  prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [CodeWidth-1:0]  code_word,
  input  logic [CountWidth-1:0] bit_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  pin_level,
  output logic                  busy_res
);

  cfg_t                  cfg;
  res_t                  res;
  logic                  s1_valid;
  logic                  s1_kind;
  logic [CodeWidth-1:0]  s1_code;
  logic [CountWidth-1:0] s1_count;
  logic                  blocked;
  logic                  go;
  logic                  take;

  assign pready   = 1'b1;
  assign blocked  = out_valid && out_stall;
  assign go       = s1_valid && !blocked;
  assign in_stall = s1_valid && blocked;
  assign take     = in_valid && !in_stall;

  nec_ir_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  nec_ir_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .kind      (s1_kind),
    .code_word (s1_code),
    .bit_count (s1_count),
    .cfg       (cfg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= take || (s1_valid && !go);
      out_valid <= go || blocked;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_kind  <= kind;
      s1_code  <= code_word;
      s1_count <= bit_count;
    end
    if (go) begin
      pin_level <= res.pin;
      busy_res  <= res.busy;
    end
  end

endmodule
